FILE: rtl/core/rgb_to_hsv_converter_core_assert.svh
// Assertion macros for the core's modules; rhc_fifo is the module that uses them.
`ifndef RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH

// Check the consequent at the same edge as the antecedent.
`define RHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent at the edge after the antecedent.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

    localparam int CH_W       = 8;
    localparam int QUO_W      = 16;
    localparam int HUE_W      = 15;
    localparam int SAT_W      = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [HUE_W-1:0] SECTOR_SPAN = 15'd3840;
    localparam logic [HUE_W-1:0] CIRCLE_SPAN = 15'd23040;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  value;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] mag;
        logic            neg;
        logic [1:0]      sector;
    } t_job;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            grey;
        logic            neg;
        logic [1:0]      sector;
    } t_tag;

    function automatic logic [HUE_W-1:0] sector_base(input logic [1:0] sector);
        logic [HUE_W-1:0] base;
        case (sector)
            SEC_RED:   base = '0;
            SEC_GREEN: base = 15'(SECTOR_SPAN << 1);
            SEC_BLUE:  base = 15'(SECTOR_SPAN << 2);
            default:   base = '0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgb_to_hsv_converter_core.sv
// Converts one 8-bit RGB pixel per clock while o_ready is high into hue (1/64 degree,
// 0..23039), saturation (65535*(max-min)/max, floored) and value (max channel). The front
// stage finds max, min and the hue sector and registers them; a FIFO_DEPTH-entry queue then
// feeds a back end of two 16-stage restoring dividers that run in lockstep, one quotient
// bit per stage, then an output register. Sustained throughput is one beat per clock while
// the output side is ready; an output stall halts the back end, and the queue and front
// register hold up to FIFO_DEPTH + 1 beats before o_ready drops.
`default_nettype none

module rgb_to_hsv_converter_core #(
    parameter int FIFO_DEPTH = rhc_pkg::FIFO_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  rhc_pkg::t_pixel i_pixel,
    output logic            o_valid,
    input  wire             i_ready,
    output rhc_pkg::t_hsv   o_hsv
);

    logic          w_front_valid;
    logic          w_front_ready;
    rhc_pkg::t_job w_front_job;
    logic          w_back_valid;
    logic          w_back_ready;
    rhc_pkg::t_job w_back_job;

    rhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    rhc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_data  (w_front_job),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_back_job)
    );

    rhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .i_job       (w_back_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hsv       (o_hsv)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rhc_front.sv
`default_nettype none

module rhc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  rhc_pkg::t_pixel     i_pixel,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output rhc_pkg::t_job       o_job
);

    logic                  r_vld;
    rhc_pkg::t_job         r_job;
    rhc_pkg::t_job         n_job;
    logic [rhc_pkg::CH_W-1:0] w_hi;
    logic [rhc_pkg::CH_W-1:0] w_lo;
    logic [rhc_pkg::CH_W-1:0] w_p;
    logic [rhc_pkg::CH_W-1:0] w_q;

    always_comb begin
        w_hi = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue > w_hi) begin
            w_hi = i_pixel.blue;
        end
        w_lo = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue < w_lo) begin
            w_lo = i_pixel.blue;
        end
        if (w_hi == i_pixel.red) begin
            n_job.sector = rhc_pkg::SEC_RED;
            w_p          = i_pixel.green;
            w_q          = i_pixel.blue;
        end else if (w_hi == i_pixel.green) begin
            n_job.sector = rhc_pkg::SEC_GREEN;
            w_p          = i_pixel.blue;
            w_q          = i_pixel.red;
        end else begin
            n_job.sector = rhc_pkg::SEC_BLUE;
            w_p          = i_pixel.red;
            w_q          = i_pixel.green;
        end
        n_job.value = w_hi;
        n_job.delta = w_hi - w_lo;
        n_job.neg   = (w_p < w_q);
        n_job.mag   = n_job.neg ? (w_q - w_p) : (w_p - w_q);
    end

    assign o_ready     = !r_vld || i_job_ready;
    assign o_job_valid = r_vld;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rhc_fifo.sv
`default_nettype none

`include "rgb_to_hsv_converter_core_assert.svh"

module rhc_fifo #(
    parameter int DEPTH = rhc_pkg::FIFO_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    input  rhc_pkg::t_job   i_push_data,
    output logic            o_pop_valid,
    input  wire             i_pop_ready,
    output rhc_pkg::t_job   o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rhc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    `RHC_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "fifo count over depth")
    `RHC_ASSERT_NEXT(a_count_up, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "fifo count missed a push")
    `RHC_ASSERT_NEXT(a_count_down, w_pop && !w_push, r_count == $past(r_count) - 1'b1, "fifo count missed a pop")

endmodule

`default_nettype wire

FILE: rtl/core/rhc_div.sv
`default_nettype none

module rhc_div #(
    parameter int QW = rhc_pkg::QUO_W,
    parameter int DW = rhc_pkg::CH_W
) (
    input  wire             i_clk,
    input  wire             i_en,
    input  wire [QW+DW-1:0] i_num,
    input  wire [DW-1:0]    i_den,
    output logic [QW-1:0]   o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW-1];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [DW-1:0] w_rem_in;
            logic [QW-1:0] w_low_in;
            logic [DW-1:0] w_den_in;
            logic [DW:0]   w_t;
            logic [DW:0]   w_sub;
            logic          w_ge;

            if (s == 0) begin : g_first
                assign w_rem_in = i_num[QW+DW-1:QW];
                assign w_low_in = i_num[QW-1:0];
                assign w_den_in = i_den;
            end else begin : g_next
                assign w_rem_in = r_rem[s-1];
                assign w_low_in = r_low[s-1];
                assign w_den_in = r_den[s-1];
            end

            assign w_t   = {w_rem_in, w_low_in[QW-1]};
            assign w_sub = w_t - {1'b0, w_den_in};
            assign w_ge  = (w_t >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
                    r_low[s] <= {w_low_in[QW-2:0], w_ge};
                end
            end

            if (s < QW - 1) begin : g_den
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_den[s] <= w_den_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_low[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/rhc_back.sv
`default_nettype none

module rhc_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_job_valid,
    output logic            o_job_ready,
    input  rhc_pkg::t_job   i_job,
    output logic            o_valid,
    input  wire             i_ready,
    output rhc_pkg::t_hsv   o_hsv
);

    localparam int QW = rhc_pkg::QUO_W;
    localparam int DW = rhc_pkg::CH_W;
    localparam int HW = rhc_pkg::HUE_W;

    logic                  w_en;
    logic                  w_pop;
    logic [QW+DW-1:0]      w_sat_num;
    logic [QW+DW-1:0]      w_hue_num;
    logic [QW+DW-1:0]      w_hue_bias;
    logic [QW-1:0]         w_sat_quo;
    logic [QW-1:0]         w_hue_quo;
    logic [QW-1:0]         r_vld;
    rhc_pkg::t_tag         r_tag [QW];
    rhc_pkg::t_tag         w_tag_in;
    rhc_pkg::t_tag         w_tag;
    logic                  r_out_vld;
    rhc_pkg::t_hsv         r_out;
    rhc_pkg::t_hsv         n_out;
    logic [HW-1:0]         w_q;
    logic [HW-1:0]         w_base;

    assign w_en        = !r_out_vld || i_ready;
    assign w_pop       = w_en && i_job_valid;
    assign o_job_ready = w_en;

    assign w_sat_num  = {i_job.delta, QW'(0)} - (QW+DW)'(i_job.delta);
    // round the quotient up for a negative difference
    assign w_hue_bias = i_job.neg ? (QW+DW)'(i_job.delta - 1'b1) : '0;
    assign w_hue_num  = (QW+DW)'({i_job.mag, 12'd0}) - (QW+DW)'({i_job.mag, 8'd0})
                        + w_hue_bias;

    assign w_tag_in.value  = i_job.value;
    assign w_tag_in.grey   = (i_job.delta == '0);
    assign w_tag_in.neg    = i_job.neg;
    assign w_tag_in.sector = i_job.sector;

    rhc_div #(
        .QW (QW),
        .DW (DW)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_sat_num),
        .i_den (i_job.value),
        .o_quo (w_sat_quo)
    );

    rhc_div #(
        .QW (QW),
        .DW (DW)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_hue_num),
        .i_den (i_job.delta),
        .o_quo (w_hue_quo)
    );

    assign w_tag  = r_tag[QW-1];
    assign w_q    = w_hue_quo[HW-1:0];
    assign w_base = rhc_pkg::sector_base(w_tag.sector);

    always_comb begin
        n_out.value = w_tag.value;
        n_out.saturation = (w_tag.value == '0) ? '0 : w_sat_quo;
        if (w_tag.grey) begin
            n_out.hue = '0;
        end else if (w_tag.neg) begin
            n_out.hue = ((w_tag.sector == rhc_pkg::SEC_RED) ? rhc_pkg::CIRCLE_SPAN : w_base)
                        - w_q;
        end else begin
            n_out.hue = w_base + w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[QW-2:0], w_pop};
            r_out_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[0] <= w_tag_in;
            for (int k = 1; k < QW; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_hsv   = r_out;

endmodule

`default_nettype wire
